[rtl/core/nei_pkg.sv]
// Shared types and constants of the next extremum index finder.
package nei_pkg;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_FIND_MAXIMUM = 1'b0,
        CFG_START_INDEX  = 1'b1
    } t_cfg_idx;

    // Widths fixed by the item and register layout.
    localparam int CFG_DATA_BITS = 16;
    localparam int START_BITS    = 16;
    localparam int INDEX_BITS    = 16;
    localparam int FLAT_BITS     = 16;

    // The flat count saturates at its top value.
    localparam logic [FLAT_BITS-1:0] FLAT_MAX = '1;

    // Control of the item held in the input register.
    typedef struct packed {
        logic valid;
        logic last;
    } t_in_ctl;

endpackage

[rtl/core/nei_if.sv]
// Channel interfaces: sample items in, result items out, configuration writes.
interface nei_in_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface nei_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] extremum_index;
    logic        found;

    modport source (output valid, output extremum_index, output found, input ready);
    modport sink   (input valid, input extremum_index, input found, output ready);
endinterface

interface nei_cfg_if;
    logic        valid;
    logic        ready;
    logic [0:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/core/nei_in_stage.sv]
// Input register that holds one sample item until the search stage takes it.
module nei_in_stage #(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nei_in_if.sink                        i_in,
    input  logic                          i_advance,
    output nei_pkg::t_in_ctl              o_ctl,
    output logic signed [SAMPLE_BITS-1:0] o_sample
);
    import nei_pkg::*;

    logic                          r_valid;
    logic                          r_last;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          accept;

    // The register takes a new item when empty or when its item moves on.
    assign i_in.ready = !r_valid || i_advance;
    assign accept     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample <= i_in.sample;
            r_last   <= i_in.last_sample;
        end
    end

    assign o_ctl.valid = r_valid;
    assign o_ctl.last  = r_last;
    assign o_sample    = r_sample;

endmodule

[rtl/core/nei_search.sv]
// Per-channel search state and the result register.
module nei_search #(
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  nei_pkg::t_in_ctl                   i_ctl,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_find_maximum,
    input  logic [nei_pkg::START_BITS-1:0]     i_start_index,
    output logic                               o_advance,
    nei_out_if.source                          o_out
);
    import nei_pkg::*;

    localparam int PW = (MAX_LENGTH > 2) ? $clog2(MAX_LENGTH) : 1;
    localparam int CW = ((PW > START_BITS) ? PW : START_BITS) + 1;
    localparam int IW = (PW > INDEX_BITS) ? PW : INDEX_BITS;
    localparam logic [PW-1:0] POS_LAST = PW'(MAX_LENGTH - 1);

    logic [PW-1:0]                 r_position, n_position;
    logic signed [SAMPLE_BITS-1:0] r_prev, n_prev;
    logic signed [SAMPLE_BITS-1:0] r_cur, n_cur;
    logic                          r_grad, n_grad;
    logic [FLAT_BITS-1:0]          r_flat, n_flat;
    logic                          r_done, n_done;

    logic                  r_out_valid;
    logic [INDEX_BITS-1:0] r_out_index, n_out_index;
    logic                  r_out_found, n_out_found;
    logic                  emit;

    logic [CW-1:0] pos_ext;
    logic [CW-1:0] start0;
    logic [CW-1:0] start1;
    logic [IW-1:0] cand;
    logic [IW-1:0] half;
    logic [IW-1:0] turn_idx;
    logic [IW-1:0] pos_wide;
    logic          grad_now;
    logic          turn;

    // The item moves on when the result register is free or being emptied.
    assign o_advance = i_ctl.valid && (!r_out_valid || o_out.ready);

    // Index arithmetic for the candidate at position minus one.
    assign pos_ext  = CW'(r_position);
    assign start0   = CW'(i_start_index);
    assign start1   = start0 + CW'(1);
    assign pos_wide = IW'(r_position);
    assign cand     = pos_wide - IW'(1);
    assign half     = IW'(r_flat >> 1);
    assign turn_idx = (half > cand) ? '0 : cand - half;

    // Gradient and turn tests against the held neighbors.
    assign grad_now = r_grad || (i_find_maximum ? (r_cur > r_prev) : (r_cur < r_prev));
    assign turn     = i_find_maximum ? (r_cur > i_sample) : (r_cur < i_sample);

    // Next search state and result for the item in the input register.
    always_comb begin
        n_position  = r_position;
        n_prev      = r_prev;
        n_cur       = r_cur;
        n_grad      = r_grad;
        n_flat      = r_flat;
        n_done      = r_done;
        emit        = 1'b0;
        n_out_index = r_out_index;
        n_out_found = r_out_found;

        if (!r_done) begin
            if (pos_ext == start0) begin
                n_prev = i_sample;
            end else if (pos_ext == start1) begin
                n_cur = i_sample;
            end else if (pos_ext > start1) begin
                n_grad = grad_now;
                if (grad_now) begin
                    if (turn) begin
                        emit        = 1'b1;
                        n_out_index = turn_idx[INDEX_BITS-1:0];
                        n_out_found = 1'b1;
                        n_done      = 1'b1;
                    end else if (r_cur == i_sample && r_flat != FLAT_MAX) begin
                        n_flat = r_flat + FLAT_BITS'(1);
                    end
                end
                n_prev = r_cur;
                n_cur  = i_sample;
            end
        end

        // The last sample closes the channel, with a fallback if nothing was found.
        if (i_ctl.last) begin
            if (!n_done) begin
                emit        = 1'b1;
                n_out_index = pos_wide[INDEX_BITS-1:0];
                n_out_found = 1'b0;
            end
            n_position = '0;
            n_prev     = '0;
            n_cur      = '0;
            n_grad     = 1'b0;
            n_flat     = '0;
            n_done     = 1'b0;
        end else if (r_position != POS_LAST) begin
            n_position = r_position + PW'(1);
        end
    end

    // Search state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_prev     <= '0;
            r_cur      <= '0;
            r_grad     <= 1'b0;
            r_flat     <= '0;
            r_done     <= 1'b0;
        end else if (o_advance) begin
            r_position <= n_position;
            r_prev     <= n_prev;
            r_cur      <= n_cur;
            r_grad     <= n_grad;
            r_flat     <= n_flat;
            r_done     <= n_done;
        end
    end

    // Result register valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance && emit) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_advance && emit) begin
            r_out_index <= n_out_index;
            r_out_found <= n_out_found;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.extremum_index = r_out_index;
    assign o_out.found          = r_out_found;

`ifndef SYNTHESIS
    // A fallback result only comes from the last sample of a channel.
    a_fallback_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && emit && !n_out_found) |-> i_ctl.last)
        else $error("fallback result on a sample that is not the last");

    // A channel whose result is out gives no second one.
    a_one_per_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && r_done) |-> !emit)
        else $error("second result in one channel");

    // The last sample leaves the channel state cleared.
    a_clear_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_advance && i_ctl.last) |=> (r_position == '0 && !r_done && !r_grad && r_flat == '0))
        else $error("channel state not cleared after the last sample");

    // The position never runs past the longest channel.
    a_position_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_position <= POS_LAST)
        else $error("position beyond the longest channel");
`endif

endmodule

[rtl/core/next_extremum_index_finder.sv]
// Top level of the next extremum index finder: configuration registers and the two stages.
//
//   channel  | dir | payload                         | handshake
//   ---------+-----+---------------------------------+------------
//   i_in     | in  | sample, last_sample             | valid/ready
//   o_out    | out | extremum_index, found           | valid/ready
//   i_cfg    | in  | index, data                     | valid/ready
//
// One sample item is accepted every cycle while o_out does not stall; the search state is
// updated in a single pass between the input register and the result register.
// A result is valid on o_out once its item has moved from the input register into the result register.
// Reset clears the channel state and loads find_maximum = 1, start_index = 0.
// A stalled result register holds the input register, which then stops i_in.
// Configuration writes are taken in any cycle.
module next_extremum_index_finder #(
    parameter int MAX_LENGTH  = 65536,
    parameter int SAMPLE_BITS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    nei_in_if.sink     i_in,
    nei_out_if.source  o_out,
    nei_cfg_if.sink    i_cfg
);
    import nei_pkg::*;

    logic                          r_find_maximum;
    logic [START_BITS-1:0]         r_start_index;
    t_in_ctl                       in_ctl;
    logic signed [SAMPLE_BITS-1:0] in_sample;
    logic                          advance;
    t_cfg_idx                      cfg_idx;

    // Configuration registers.
    assign i_cfg.ready = 1'b1;
    assign cfg_idx     = t_cfg_idx'(i_cfg.index);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_find_maximum <= 1'b1;
            r_start_index  <= '0;
        end else if (i_cfg.valid) begin
            unique case (cfg_idx)
                CFG_FIND_MAXIMUM: r_find_maximum <= i_cfg.data[0];
                CFG_START_INDEX:  r_start_index  <= i_cfg.data[START_BITS-1:0];
                default:          r_find_maximum <= r_find_maximum;
            endcase
        end
    end

    // Input register.
    nei_in_stage #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (advance),
        .o_ctl     (in_ctl),
        .o_sample  (in_sample)
    );

    // Search state and result register.
    nei_search #(
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_search (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (in_ctl),
        .i_sample       (in_sample),
        .i_find_maximum (r_find_maximum),
        .i_start_index  (r_start_index),
        .o_advance      (advance),
        .o_out          (o_out)
    );

endmodule

[bench/testbench.sv]
// Self-checking testbench of the next extremum index finder with a built-in search predictor.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import nei_pkg::*;

    localparam int MAX_LENGTH    = 65536;
    localparam int SAMPLE_BITS   = 16;
    localparam int SETTLE_CYCLES = 8;

    // One sample item as offered on the input channel.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last;
    } t_sample_item;

    // One result item: the reported index and whether a turn was found.
    typedef struct packed {
        logic [INDEX_BITS-1:0] index;
        logic                  found;
    } t_extremum;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    nei_in_if #(.SAMPLE_BITS(SAMPLE_BITS)) in_ch ();
    nei_out_if                             out_ch ();
    nei_cfg_if                             cfg_ch ();

    next_extremum_index_finder #(
        .MAX_LENGTH  (MAX_LENGTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #10 i_clk = ~i_clk;

    // Stimulus and expectation stores.
    t_sample_item sample_queue[$];
    t_extremum    expected_extrema[$];

    int unsigned samples_offered = 0;
    int unsigned samples_taken   = 0;
    int unsigned cfg_writes      = 0;
    int unsigned mismatches      = 0;
    int          in_gap          = 0;
    int          out_stall       = 0;
    bit          idle_on         = 1'b1;

    // Register copies and search state of the predictor.
    bit                            cfg_find_max;
    int unsigned                   cfg_start;
    int unsigned                   search_pos;
    logic signed [SAMPLE_BITS-1:0] prev_val;
    logic signed [SAMPLE_BITS-1:0] cur_val;
    bit                            grad_seen;
    logic [FLAT_BITS-1:0]          flat_cnt;
    bit                            search_done;

    function automatic void clear_search();
        search_pos  = 0;
        prev_val    = '0;
        cur_val     = '0;
        grad_seen   = 1'b0;
        flat_cnt    = '0;
        search_done = 1'b0;
    endfunction

    // Advance the search by one sample; returns 1 when the sample yields a result.
    function automatic bit step_search(input logic signed [SAMPLE_BITS-1:0] s,
                                       input logic last_s, output t_extremum res);
        int unsigned p;
        int unsigned cand;
        int unsigned half;
        bit          hit;
        bit          turn;
        p   = search_pos;
        hit = 1'b0;
        res = '0;
        if (!search_done) begin
            if (p == cfg_start) begin
                prev_val = s;
            end else if (p == cfg_start + 1) begin
                cur_val = s;
            end else if (p > cfg_start + 1) begin
                cand = p - 1;
                if (!grad_seen) begin
                    grad_seen = cfg_find_max ? (cur_val > prev_val) : (cur_val < prev_val);
                end
                if (grad_seen) begin
                    turn = cfg_find_max ? (cur_val > s) : (cur_val < s);
                    if (turn) begin
                        half        = 32'(flat_cnt) / 2;
                        res.index   = (half > cand) ? '0 : INDEX_BITS'(cand - half);
                        res.found   = 1'b1;
                        hit         = 1'b1;
                        search_done = 1'b1;
                    end else if (cur_val == s && flat_cnt != FLAT_MAX) begin
                        flat_cnt = flat_cnt + FLAT_BITS'(1);
                    end
                end
                prev_val = cur_val;
                cur_val  = s;
            end
        end
        // The last sample closes the channel, with the fallback if nothing was found.
        if (last_s) begin
            if (!search_done) begin
                res.index = INDEX_BITS'(p);
                res.found = 1'b0;
                hit       = 1'b1;
            end
            clear_search();
        end else if (search_pos < MAX_LENGTH - 1) begin
            search_pos = search_pos + 1;
        end
        return hit;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return 0;
        end
        if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic void report_mismatch(input t_extremum want, input t_extremum got,
                                            input bit orphan);
        mismatches++;
        if (mismatches <= 10) begin
            if (orphan) begin
                $display("unexpected result: index %0d found %0b", got.index, got.found);
            end else begin
                $display("mismatch: expected index %0d found %0b, got index %0d found %0b",
                         want.index, want.found, got.index, got.found);
            end
        end
    endfunction

    // Monitor: check results, track register writes, predict each accepted sample.
    always @(posedge i_clk) begin
        t_extremum got;
        t_extremum want;
        t_extremum pred;
        if (!i_rst_n) begin
            cfg_find_max = 1'b1;
            cfg_start    = 0;
            clear_search();
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.index = out_ch.extremum_index;
                got.found = out_ch.found;
                if (expected_extrema.size() == 0) begin
                    report_mismatch('0, got, 1'b1);
                end else begin
                    want = expected_extrema.pop_front();
                    if (got !== want) begin
                        report_mismatch(want, got, 1'b0);
                    end
                end
            end
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_FIND_MAXIMUM: cfg_find_max = cfg_ch.data[0];
                    CFG_START_INDEX:  cfg_start    = 32'(cfg_ch.data);
                    default: ;
                endcase
                cfg_writes++;
            end
            if (in_ch.valid && in_ch.ready) begin
                if (step_search(in_ch.sample, in_ch.last_sample, pred)) begin
                    expected_extrema.push_back(pred);
                end
                samples_taken++;
            end
        end
    end

    // Sample driver: offers queued items with random gaps between them.
    always @(negedge i_clk) begin
        t_sample_item item;
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!(in_ch.valid && samples_taken != samples_offered)) begin
            if (in_gap > 0) begin
                in_ch.valid <= 1'b0;
                in_gap--;
            end else if (sample_queue.size() > 0) begin
                item = sample_queue.pop_front();
                in_ch.valid       <= 1'b1;
                in_ch.sample      <= item.sample;
                in_ch.last_sample <= item.last;
                samples_offered++;
                in_gap = idle_on ? pick_gap() : 0;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Result receiver: stalls at random while idling is enabled.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else if (out_stall > 0) begin
            out_ch.ready <= 1'b0;
            out_stall--;
        end else begin
            out_ch.ready <= 1'b1;
            if (idle_on && $urandom_range(0, 3) == 0) begin
                out_stall = pick_gap();
            end
        end
    end

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_BITS-1:0] value);
        int unsigned target;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        target = cfg_writes + 1;
        do @(negedge i_clk); while (cfg_writes < target);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every queued sample is taken and every result has arrived.
    task automatic wait_idle();
        while (sample_queue.size() != 0 || samples_taken != samples_offered ||
               expected_extrema.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_config(input bit find_max, input logic [START_BITS-1:0] start);
        wait_idle();
        write_reg(CFG_FIND_MAXIMUM, CFG_DATA_BITS'(find_max));
        write_reg(CFG_START_INDEX, start);
    endtask

    task automatic push_sample(input int value, input bit last);
        t_sample_item item;
        item.sample = SAMPLE_BITS'(value);
        item.last   = last;
        sample_queue.push_back(item);
    endtask

    // Queue one channel: random slopes and plateaus, or pure noise.
    task automatic add_channel(input int len, input bit noise, input bit terminate);
        int level;
        int dir;
        for (int i = 0; i < len; i++) begin
            if (i == 0) begin
                level = $signed(16'($urandom));
                dir   = $urandom_range(0, 2) - 1;
            end else if (noise) begin
                level = $signed(16'($urandom));
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    dir = $urandom_range(0, 2) - 1;
                end
                level = level + dir * $urandom_range(1, 4);
                if ($urandom_range(0, 19) == 0) begin
                    level = $urandom_range(0, 1) ? 32767 : -32768;
                end
            end
            if (level > 32767) begin
                level = 32767;
            end else if (level < -32768) begin
                level = -32768;
            end
            push_sample(level, terminate && i == len - 1);
        end
    endtask

    initial begin
        int added;
        int len;
        logic [START_BITS-1:0] start;
        in_ch.valid        = 1'b0;
        in_ch.sample       = '0;
        in_ch.last_sample  = 1'b0;
        out_ch.ready       = 1'b0;
        cfg_ch.valid       = 1'b0;
        cfg_ch.index       = '0;
        cfg_ch.data        = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: maximum search from index zero.
        set_config(1'b1, '0);
        push_sample(0, 0); push_sample(5, 0); push_sample(3, 1);
        // A single-sample channel never reaches the search.
        push_sample(7, 1);
        // Plateau at the peak moves the index back by half the flat count.
        push_sample(-32768, 0); push_sample(32767, 0); push_sample(32767, 0);
        push_sample(32767, 0); push_sample(-32768, 1);
        // No rise at all ends in the fallback.
        push_sample(5, 0); push_sample(4, 1);
        // Turn on the last sample gives only the found result.
        push_sample(0, 0); push_sample(1, 0); push_sample(0, 1);
        // Samples after a find give nothing.
        push_sample(0, 0); push_sample(2, 0); push_sample(1, 0); push_sample(7, 1);

        // Directed: minimum search starting later, then a channel left open.
        set_config(1'b0, 16'd2);
        push_sample(9, 0); push_sample(9, 0); push_sample(5, 0);
        push_sample(3, 0); push_sample(4, 0); push_sample(1, 1);
        push_sample(7, 0); push_sample(7, 1);
        push_sample(10, 0); push_sample(8, 0);

        // Directed: start at the top index, the open channel continues.
        set_config(1'b1, 16'hFFFF);
        push_sample(-1, 0); push_sample(0, 1);
        push_sample(3, 0); push_sample(2, 0); push_sample(4, 1);

        // Random phases of well-formed channels with some noise, at times followed by an open channel.
        for (int ph = 0; ph < 6; ph++) begin
            case ($urandom_range(0, 5))
                0:       start = '0;
                1:       start = 16'd1;
                2:       start = START_BITS'($urandom_range(2, 4));
                3:       start = START_BITS'($urandom_range(0, 12));
                default: start = START_BITS'($urandom_range(0, 2));
            endcase
            if (ph == 0) begin
                start = '0;
            end
            set_config(1'($urandom_range(0, 1)), start);
            idle_on = (ph != 2);
            added = 0;
            while (added < 140) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 60)
                                                  : $urandom_range(1, 16);
                add_channel(len, $urandom_range(0, 9) == 0, 1'b1);
                added += len;
            end
            if ($urandom_range(0, 3) == 0) begin
                add_channel($urandom_range(1, 6), 1'b0, 1'b0);
            end
        end

        wait_idle();
        if (mismatches == 0 && expected_extrema.size() == 0) begin
            $display("[next_extremum_index_finder] OK");
        end else begin
            $display("[next_extremum_index_finder] ERROR");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #30ms;
        $display("[next_extremum_index_finder] ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/core/nei_pkg.sv
rtl/core/nei_if.sv
rtl/core/nei_in_stage.sv
rtl/core/nei_search.sv
rtl/core/next_extremum_index_finder.sv
bench/testbench.sv
